[src/ngga_pkg.sv]
// Shared constants, types and conversion tables of the GGA position parser.
package ngga_pkg;

   // Field widths of the words on the two channels.
   localparam int RX_W   = 8;
   localparam int LAT_W  = 28;
   localparam int LON_W  = 29;
   localparam int HDOP_W = 14;

   // Fraction digits of a coordinate that are taken into account (1 to 6).
   localparam int FRACTION_DIGITS = 5;

   // Internal widths of the coordinate and number accumulators.
   localparam int INT_W   = 17;
   localparam int REM_W   = 7;
   localparam int DSUM_W  = 31;
   localparam int MQ_W    = 21;
   localparam int MR_W    = 6;
   localparam int FQ_W    = 14;
   localparam int PHASE_W = 4;
   localparam int QUAL_W  = 8;
   localparam int HDR_W   = 3;

   localparam int UDEG_SCALE = 1000000;
   localparam int MIN_DIV    = 60;
   localparam int POW10 [7]  = '{1, 10, 100, 1000, 10000, 100000, 1000000};

   localparam logic [INT_W-1:0]  INT_SAT      = 17'd131071;
   localparam logic [REM_W-1:0]  REM_SAT      = 7'd71;
   localparam logic [DSUM_W-1:0] DEG_SAT_UDEG = 31'd1310000000;
   localparam logic [DSUM_W-1:0] UDEG_PER_DEG = 31'd1000000;
   localparam logic [DSUM_W-1:0] LAT_LIMIT    = 31'd90000000;
   localparam logic [DSUM_W-1:0] LON_LIMIT    = 31'd180000000;
   localparam logic [HDOP_W-1:0] HDOP_SAT     = 14'd9999;
   localparam logic [QUAL_W-1:0] QUAL_SAT     = 8'd255;

   // Number phase: zero while integer digits are read, then the position of
   // the next fraction digit, and a closed marker once the number has ended.
   localparam logic [PHASE_W-1:0] PHASE_INT    = 4'd0;
   localparam logic [PHASE_W-1:0] PHASE_FRAC1  = 4'd1;
   localparam logic [PHASE_W-1:0] PHASE_FRAC2  = 4'd2;
   localparam logic [PHASE_W-1:0] PHASE_FRAC3  = 4'd3;
   localparam logic [PHASE_W-1:0] PHASE_CLOSED = 4'd15;

   // Header progress: count of matched prefix characters, or a mismatch.
   localparam logic [HDR_W-1:0] HDR_ALT_POS = 3'd2;
   localparam logic [HDR_W-1:0] HDR_LEN     = 3'd6;
   localparam logic [HDR_W-1:0] HDR_FAIL    = 3'd7;

   // Stored reversed, so that index 0 holds the first character of "$GNGGA".
   localparam logic [5:0][RX_W-1:0] HEADER_TEXT = "AGGNG$";

   localparam logic [RX_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [RX_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [RX_W-1:0] CHAR_COMMA = ",";
   localparam logic [RX_W-1:0] CHAR_DOT   = ".";
   localparam logic [RX_W-1:0] CHAR_0     = "0";
   localparam logic [RX_W-1:0] CHAR_9     = "9";
   localparam logic [RX_W-1:0] CHAR_P     = "P";
   localparam logic [RX_W-1:0] CHAR_S     = "S";
   localparam logic [RX_W-1:0] CHAR_W     = "W";

   // Field numbers within a GGA sentence.
   localparam int FIELD_LAT     = 2;
   localparam int FIELD_NS      = 3;
   localparam int FIELD_LON     = 4;
   localparam int FIELD_EW      = 5;
   localparam int FIELD_QUAL    = 6;
   localparam int FIELD_HDOP    = 8;
   localparam int FIELD_MIN_FIX = 8;

   // Running coordinate: integer part, its whole degrees already scaled to
   // microdegrees, its minutes below one hundred, and the quotient and
   // remainder of the minute value in millionths divided by sixty.
   typedef struct packed {
      logic [INT_W-1:0]  int_acc;
      logic [REM_W-1:0]  rem;
      logic [DSUM_W-1:0] deg_udeg;
      logic [MQ_W-1:0]   min_q;
      logic [MR_W-1:0]   min_r;
   } coord_type;

   typedef logic [99:0][MQ_W+MR_W-1:0]     min_tab_type;
   typedef logic [6:0][9:0][FQ_W+MR_W-1:0] frac_tab_type;

   // Whole minutes times one million, divided by sixty: quotient and remainder.
   function automatic min_tab_type make_min_tab();
      min_tab_type tab;
      tab = '0;
      for (int r = 0; r < 100; r++) begin
         tab[r] = {MQ_W'((r * UDEG_SCALE) / MIN_DIV), MR_W'((r * UDEG_SCALE) % MIN_DIV)};
      end
      return tab;
   endfunction

   // A fraction digit at position k weighs d * 10^(6-k) millionths of a minute.
   function automatic frac_tab_type make_frac_tab();
      frac_tab_type tab;
      tab = '0;
      for (int k = 1; k < 7; k++) begin
         for (int d = 0; d < 10; d++) begin
            tab[k][d] = {FQ_W'((d * POW10[6-k]) / MIN_DIV),
                         MR_W'((d * POW10[6-k]) % MIN_DIV)};
         end
      end
      return tab;
   endfunction

   localparam min_tab_type  MIN_TAB  = make_min_tab();
   localparam frac_tab_type FRAC_TAB = make_frac_tab();

endpackage

[src/ngga_if.sv]
// Valid/ready channel interfaces for received bytes and parsed position words.
interface ngga_req_if;
   logic                      valid;
   logic                      ready;
   logic [ngga_pkg::RX_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface ngga_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               fix_valid;
   logic signed [ngga_pkg::LAT_W-1:0]  latitude_udeg;
   logic signed [ngga_pkg::LON_W-1:0]  longitude_udeg;
   logic [ngga_pkg::HDOP_W-1:0]        hdop_centi;

   modport source (output valid, output fix_valid, output latitude_udeg,
                   output longitude_udeg, output hdop_centi, input ready);
   modport sink (input valid, input fix_valid, input latitude_udeg,
                 input longitude_udeg, input hdop_centi, output ready);
endinterface

[src/nmea_gga_position_parser_top.sv]
// GGA sentence parser: byte-wise line state and position word output.
// A taken newline word waits in the input register; once processed, its result word is registered.
// Throughput: one byte word per clock, set by the combinational update of the line state.
// While a result word waits on a low ready the parser stalls; an empty input register still
// takes one word. Reset (synchronous) clears the line state, the held fix, position and HDOP.
module nmea_gga_position_parser_top #(
   parameter int LINE_CHARS = 128,
   parameter int MAX_FIELDS = 15
) (
   input logic        clock,
   input logic        reset,
   ngga_req_if.sink   req_chan,
   ngga_rsp_if.source rsp_chan
);
   import ngga_pkg::*;

   localparam int KEPT_W  = $clog2(LINE_CHARS);
   localparam int FIELD_W = $clog2(MAX_FIELDS);
   localparam int PHASE_TOP = (FRACTION_DIGITS + 1 > 3) ? FRACTION_DIGITS + 1 : 3;
   localparam logic [KEPT_W-1:0]  KEPT_MAX   = KEPT_W'(LINE_CHARS - 1);
   localparam logic [FIELD_W-1:0] FIELD_LAST = FIELD_W'(MAX_FIELDS - 1);
   localparam logic signed [LAT_W-1:0] LAT_POS = LAT_W'(LAT_LIMIT);
   localparam logic signed [LON_W-1:0] LON_POS = LON_W'(LON_LIMIT);

   logic                byte_vld_ff, byte_vld_in;
   logic [RX_W-1:0]     byte_ff, byte_in;
   logic [KEPT_W-1:0]   kept_ff, kept_in;
   logic [HDR_W-1:0]    hdr_ff, hdr_in;
   logic [FIELD_W-1:0]  field_ff, field_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   coord_type           lat_coord_ff, lat_coord_in;
   coord_type           lon_coord_ff, lon_coord_in;
   logic                south_ff, south_in;
   logic                west_ff, west_in;
   logic [QUAL_W-1:0]   qual_ff, qual_in;
   logic [HDOP_W-1:0]   hdop_acc_ff, hdop_acc_in;
   logic                held_fix_ff, held_fix_in;
   logic signed [LAT_W-1:0] held_lat_ff, held_lat_in;
   logic signed [LON_W-1:0] held_lon_ff, held_lon_in;
   logic [HDOP_W-1:0]   held_hdop_ff, held_hdop_in;
   logic                rsp_vld_ff, rsp_vld_in;

   logic                adv;
   logic                proc;
   logic                line_end;
   logic                is_digit;
   logic [3:0]          dig;
   logic                fix_ok;
   logic [DSUM_W-1:0]   lat_sum, lon_sum, lat_mag, lon_mag;
   logic [11:0]         qual_val;
   logic [HDOP_W+3:0]   hdop_val;

   // One digit of a ddmm.f coordinate. Whole degrees and whole minutes are kept
   // apart, so that the final conversion needs no divider.
   function automatic coord_type coord_digit(coord_type cur, logic [3:0] d,
                                             logic [PHASE_W-1:0] phase);
      coord_type               nxt;
      logic [INT_W+3:0]        ival;
      logic [9:0]              tval;
      logic [3:0]              carry;
      logic [DSUM_W+3:0]       dval;
      logic [FQ_W+MR_W-1:0]    fent;
      logic [MR_W:0]           rsum;
      nxt = cur;
      if (phase == PHASE_INT) begin
         ival = ({4'd0, cur.int_acc} << 3) + ({4'd0, cur.int_acc} << 1) + (INT_W+4)'(d);
         if (ival > (INT_W+4)'(INT_SAT)) begin
            nxt.int_acc  = INT_SAT;
            nxt.rem      = REM_SAT;
            nxt.deg_udeg = DEG_SAT_UDEG;
         end else begin
            tval  = 10'(cur.rem) * 10'd10 + 10'(d);
            carry = 4'd0;
            for (int k = 1; k < 10; k++) begin
               if (tval >= 10'(100 * k)) begin
                  carry = 4'(k);
               end
            end
            dval = (DSUM_W+4)'(cur.deg_udeg) * (DSUM_W+4)'(10)
                 + (DSUM_W+4)'(carry) * (DSUM_W+4)'(UDEG_PER_DEG);
            nxt.int_acc  = ival[INT_W-1:0];
            nxt.rem      = REM_W'(tval - 10'(carry) * 10'd100);
            nxt.deg_udeg = dval[DSUM_W-1:0];
         end
         {nxt.min_q, nxt.min_r} = MIN_TAB[nxt.rem];
      end else if (phase <= PHASE_W'(FRACTION_DIGITS)) begin
         fent = FRAC_TAB[phase[2:0]][d];
         rsum = {1'b0, cur.min_r} + {1'b0, fent[MR_W-1:0]};
         if (rsum >= (MR_W+1)'(MIN_DIV)) begin
            nxt.min_r = MR_W'(rsum - (MR_W+1)'(MIN_DIV));
            nxt.min_q = cur.min_q + MQ_W'(fent[FQ_W+MR_W-1:MR_W]) + MQ_W'(1);
         end else begin
            nxt.min_r = rsum[MR_W-1:0];
            nxt.min_q = cur.min_q + MQ_W'(fent[FQ_W+MR_W-1:MR_W]);
         end
      end
      return nxt;
   endfunction

   assign adv              = !rsp_vld_ff || rsp_chan.ready;
   assign req_chan.ready   = !byte_vld_ff || adv;
   assign proc             = byte_vld_ff && adv;
   assign line_end         = proc && (byte_ff == CHAR_LF) && (hdr_ff == HDR_LEN);
   assign is_digit         = (byte_ff >= CHAR_0) && (byte_ff <= CHAR_9);
   assign dig              = byte_ff[3:0];
   assign fix_ok           = (field_ff >= FIELD_W'(FIELD_MIN_FIX)) && (qual_ff != '0);

   assign lat_sum = lat_coord_ff.deg_udeg + DSUM_W'(lat_coord_ff.min_q);
   assign lon_sum = lon_coord_ff.deg_udeg + DSUM_W'(lon_coord_ff.min_q);
   assign lat_mag = (lat_sum > LAT_LIMIT) ? LAT_LIMIT : lat_sum;
   assign lon_mag = (lon_sum > LON_LIMIT) ? LON_LIMIT : lon_sum;

   assign qual_val = 12'(qual_ff) * 12'd10 + 12'(dig);

   always_comb begin
      priority case (phase_ff)
         PHASE_INT:   hdop_val = (HDOP_W+4)'(hdop_acc_ff) * (HDOP_W+4)'(10)
                               + (HDOP_W+4)'(dig) * (HDOP_W+4)'(100);
         PHASE_FRAC1: hdop_val = (HDOP_W+4)'(hdop_acc_ff) + (HDOP_W+4)'(dig) * (HDOP_W+4)'(10);
         PHASE_FRAC2: hdop_val = (HDOP_W+4)'(hdop_acc_ff) + (HDOP_W+4)'(dig);
         default:     hdop_val = (HDOP_W+4)'(hdop_acc_ff);
      endcase
   end

   always_comb begin
      byte_vld_in  = byte_vld_ff;
      byte_in      = byte_ff;
      kept_in      = kept_ff;
      hdr_in       = hdr_ff;
      field_in     = field_ff;
      phase_in     = phase_ff;
      lat_coord_in = lat_coord_ff;
      lon_coord_in = lon_coord_ff;
      south_in     = south_ff;
      west_in      = west_ff;
      qual_in      = qual_ff;
      hdop_acc_in  = hdop_acc_ff;
      held_fix_in  = held_fix_ff;
      held_lat_in  = held_lat_ff;
      held_lon_in  = held_lon_ff;
      held_hdop_in = held_hdop_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;

      if (req_chan.ready) begin
         byte_vld_in = req_chan.valid;
         byte_in     = req_chan.rx_byte;
      end

      if (proc) begin
         priority if (byte_ff == CHAR_LF) begin
            if (hdr_ff == HDR_LEN) begin
               rsp_vld_in = 1'b1;
               if (fix_ok) begin
                  held_fix_in  = 1'b1;
                  held_lat_in  = south_ff ? -$signed(LAT_W'(lat_mag)) : $signed(LAT_W'(lat_mag));
                  held_lon_in  = west_ff ? -$signed(LON_W'(lon_mag)) : $signed(LON_W'(lon_mag));
                  held_hdop_in = hdop_acc_ff;
               end else begin
                  held_fix_in = 1'b0;
               end
            end
            kept_in      = '0;
            hdr_in       = '0;
            field_in     = '0;
            phase_in     = PHASE_INT;
            lat_coord_in = '0;
            lon_coord_in = '0;
            south_in     = 1'b0;
            west_in      = 1'b0;
            qual_in      = '0;
            hdop_acc_in  = '0;
         end else if (byte_ff == CHAR_CR) begin
            // Carriage returns are dropped without counting as kept characters.
            kept_in = kept_ff;
         end else if (kept_ff != KEPT_MAX) begin
            kept_in = kept_ff + KEPT_W'(1);
            if (hdr_ff < HDR_LEN) begin
               if ((byte_ff == HEADER_TEXT[hdr_ff]) ||
                   ((hdr_ff == HDR_ALT_POS) && (byte_ff == CHAR_P))) begin
                  hdr_in = hdr_ff + HDR_W'(1);
               end else begin
                  hdr_in = HDR_FAIL;
               end
            end
            // In the last field a comma is an ordinary character and does not start a new field.
            if ((byte_ff == CHAR_COMMA) && (field_ff != FIELD_LAST)) begin
               field_in = field_ff + FIELD_W'(1);
               phase_in = PHASE_INT;
            end else begin
               unique case (field_ff)
                  FIELD_W'(FIELD_LAT), FIELD_W'(FIELD_LON): begin
                     if (phase_ff != PHASE_CLOSED) begin
                        if (is_digit) begin
                           if (field_ff == FIELD_W'(FIELD_LAT)) begin
                              lat_coord_in = coord_digit(lat_coord_ff, dig, phase_ff);
                           end else begin
                              lon_coord_in = coord_digit(lon_coord_ff, dig, phase_ff);
                           end
                           if ((phase_ff != PHASE_INT) &&
                               (phase_ff <= PHASE_W'(FRACTION_DIGITS))) begin
                              phase_in = phase_ff + PHASE_W'(1);
                           end
                        end else if ((byte_ff == CHAR_DOT) && (phase_ff == PHASE_INT)) begin
                           phase_in = PHASE_FRAC1;
                        end else begin
                           phase_in = PHASE_CLOSED;
                        end
                     end
                  end
                  FIELD_W'(FIELD_NS): begin
                     if (phase_ff == PHASE_INT) begin
                        south_in = (byte_ff == CHAR_S);
                     end
                     phase_in = PHASE_CLOSED;
                  end
                  FIELD_W'(FIELD_EW): begin
                     if (phase_ff == PHASE_INT) begin
                        west_in = (byte_ff == CHAR_W);
                     end
                     phase_in = PHASE_CLOSED;
                  end
                  FIELD_W'(FIELD_QUAL): begin
                     if (phase_ff != PHASE_CLOSED) begin
                        if (is_digit) begin
                           qual_in = (qual_val > 12'(QUAL_SAT)) ? QUAL_SAT : qual_val[QUAL_W-1:0];
                        end else begin
                           phase_in = PHASE_CLOSED;
                        end
                     end
                  end
                  FIELD_W'(FIELD_HDOP): begin
                     if (phase_ff != PHASE_CLOSED) begin
                        if (is_digit) begin
                           hdop_acc_in = (hdop_val > (HDOP_W+4)'(HDOP_SAT)) ?
                                         HDOP_SAT : hdop_val[HDOP_W-1:0];
                           if ((phase_ff == PHASE_FRAC1) || (phase_ff == PHASE_FRAC2)) begin
                              phase_in = phase_ff + PHASE_W'(1);
                           end
                        end else if ((byte_ff == CHAR_DOT) && (phase_ff == PHASE_INT)) begin
                           phase_in = PHASE_FRAC1;
                        end else begin
                           phase_in = PHASE_CLOSED;
                        end
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end else begin
            // Characters past the kept part of a line are ignored.
            kept_in = kept_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff  <= 1'b0;
         kept_ff      <= '0;
         hdr_ff       <= '0;
         field_ff     <= '0;
         phase_ff     <= PHASE_INT;
         lat_coord_ff <= '0;
         lon_coord_ff <= '0;
         south_ff     <= 1'b0;
         west_ff      <= 1'b0;
         qual_ff      <= '0;
         hdop_acc_ff  <= '0;
         held_fix_ff  <= 1'b0;
         held_lat_ff  <= '0;
         held_lon_ff  <= '0;
         held_hdop_ff <= '0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         byte_vld_ff  <= byte_vld_in;
         kept_ff      <= kept_in;
         hdr_ff       <= hdr_in;
         field_ff     <= field_in;
         phase_ff     <= phase_in;
         lat_coord_ff <= lat_coord_in;
         lon_coord_ff <= lon_coord_in;
         south_ff     <= south_in;
         west_ff      <= west_in;
         qual_ff      <= qual_in;
         hdop_acc_ff  <= hdop_acc_in;
         held_fix_ff  <= held_fix_in;
         held_lat_ff  <= held_lat_in;
         held_lon_ff  <= held_lon_in;
         held_hdop_ff <= held_hdop_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      byte_ff <= byte_in;
   end

   // The held position doubles as the result register; it only moves when the slot is free.
   assign rsp_chan.valid          = rsp_vld_ff;
   assign rsp_chan.fix_valid      = held_fix_ff;
   assign rsp_chan.latitude_udeg  = held_lat_ff;
   assign rsp_chan.longitude_udeg = held_lon_ff;
   assign rsp_chan.hdop_centi     = held_hdop_ff;

   a_result_follows_line: assert property (@(posedge clock) disable iff (reset)
      line_end |=> rsp_vld_ff)
      else $error("A matching line end did not raise a result word.");

   a_result_has_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(line_end))
      else $error("A result word appeared without a matching line end.");

   a_line_counters: assert property (@(posedge clock) disable iff (reset)
      (kept_ff <= KEPT_MAX) && (field_ff <= FIELD_LAST))
      else $error("Kept character count or field number ran past its limit.");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff <= PHASE_W'(PHASE_TOP)) || (phase_ff == PHASE_CLOSED))
      else $error("Number phase left its legal range.");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      (held_lat_ff <= LAT_POS) && (held_lat_ff >= -LAT_POS) &&
      (held_lon_ff <= LON_POS) && (held_lon_ff >= -LON_POS))
      else $error("Held position is outside the clamped range.");

endmodule
